[sv/utf8vtc_pkg.sv]
// Package with shared types, constants and the whitespace classifier of the UTF-8 trim counter.
package utf8vtc_pkg;

    // Fixed widths of the result fields and of the limit register.
    localparam int TB_W  = 9;
    localparam int TE_W  = 10;
    localparam int CNT_W = 10;
    localparam int MAXCP_W = 10;
    localparam logic [MAXCP_W-1:0] MAXCP_RESET = 10'd80;

    // Codepoint value width.
    localparam int CP_W = 21;

    // Lead byte and range limits of strict UTF-8.
    localparam logic [7:0] LEAD2_MIN = 8'hC2;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD4_MAX = 8'hF4;
    localparam logic [CP_W-1:0] CP_MIN3    = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN4    = 21'h010000;
    localparam logic [CP_W-1:0] CP_SURR_LO = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;

    // Sequence lengths.
    localparam logic [2:0] SEQ_LEN1 = 3'd1;
    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_TOO_MANY = 3'd3,
        ST_TOO_LONG = 3'd4
    } t_status;

    // Decoder state carried from byte to byte.
    typedef struct packed {
        logic [1:0]      pending;
        logic [2:0]      seq_len;
        logic [CP_W-1:0] partial;
    } t_dec_state;

    // What one byte did to the decoder.
    typedef struct packed {
        logic lead;   // byte opened a new sequence
        logic done;   // byte completed a codepoint
        logic space;  // completed codepoint is whitespace
        logic bad;    // byte is not legal here
    } t_dec_evt;

    function automatic logic is_space(input logic [CP_W-1:0] cp);
        logic res;
        res = (cp == 21'h20) || (cp >= 21'h09 && cp <= 21'h0D) || (cp == 21'h85) ||
              (cp == 21'hA0) || (cp == 21'h1680) ||
              (cp >= 21'h2000 && cp <= 21'h200A) || (cp == 21'h2028) ||
              (cp == 21'h2029) || (cp == 21'h202F) || (cp == 21'h205F) ||
              (cp == 21'h3000);
        return res;
    endfunction

endpackage

[sv/utf8vtc_top.sv]
// Top level of the streaming UTF-8 validator with whitespace trim and codepoint count.
//
// Channel  Dir  Handshake                 Payload
// in       in   i_in_valid / o_in_stall   i_data_byte, i_byte_present, i_end_of_text
// out      out  o_out_valid / i_out_stall o_status, o_trim_begin, o_trim_end,
//                                         o_cp_count
// cfg      in   i_cfg_valid / o_cfg_ready i_cfg_data (max_codepoints)
//
// One beat is taken every cycle unless the input stalls; each input beat lands in an
// input register and is decoded from there by one pass of combinational logic into
// the text state. A verdict is loaded into the result register when its end-of-text
// beat leaves the input register.
// Bytes keep flowing while a verdict waits; only an end-of-text beat waits for the
// result register to drain, so the input stalls only behind an unconsumed verdict.
// Reset (synchronous, active low) clears the text state and sets the limit to 80.
module utf8_validate_trim_count
    import utf8vtc_pkg::*;
#(
    parameter int MAX_TEXT_BYTES = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_byte_present,
    input  logic               i_end_of_text,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic [TB_W-1:0]    o_trim_begin,
    output logic [TE_W-1:0]    o_trim_end,
    output logic [CNT_W-1:0]   o_cp_count,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [MAXCP_W-1:0] i_cfg_data
);

    // Positions and codepoint indices both run from zero up to MAX_TEXT_BYTES.
    localparam int PW = $clog2(MAX_TEXT_BYTES + 1);
    localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_TEXT_BYTES);

    // Input register.
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_present;
    logic       r_s1_end;

    // Text state.
    t_dec_state          r_dec, n_dec;
    logic [PW-1:0]       r_pos, n_pos;
    logic [PW-1:0]       r_seq_start, n_seq_start;
    logic [PW-1:0]       r_cp_idx, n_cp_idx;
    logic                r_found, n_found;
    logic [PW-1:0]       r_first_off, n_first_off;
    logic [PW-1:0]       r_first_idx, n_first_idx;
    logic [PW-1:0]       r_last_end, n_last_end;
    logic [PW-1:0]       r_last_idx, n_last_idx;
    t_status             r_err, n_err;
    logic [MAXCP_W-1:0]  r_max_cp;

    // Result register.
    logic               r_out_valid;
    t_status            r_status, n_status;
    logic [TB_W-1:0]    r_tb, n_tb;
    logic [TE_W-1:0]    r_te, n_te;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    t_dec_state w_dec_next;
    t_dec_evt   w_evt;
    logic       w_out_free;
    logic       w_s1_adv;
    logic       w_in_accept;
    logic [PW-1:0] w_pos_inc;
    logic [PW-1:0] w_cp_start;
    logic [PW-1:0] w_span_cnt;
    logic [31:0]   w_first32;
    logic [31:0]   w_last32;
    logic [31:0]   w_cnt32;

    // The output register frees up this cycle if empty or being taken.
    assign w_out_free  = !r_out_valid || !i_out_stall;
    // Ordinary bytes always move on; an end-of-text beat needs room for its verdict.
    assign w_s1_adv    = r_s1_valid && (!r_s1_end || w_out_free);
    assign o_in_stall  = r_s1_valid && !w_s1_adv;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    utf8vtc_decode u_decode (
        .i_byte (r_s1_byte),
        .i_cur  (r_dec),
        .o_next (w_dec_next),
        .o_evt  (w_evt)
    );

    assign w_pos_inc  = r_pos + 1'b1;
    // A one-byte codepoint starts at the current byte; longer ones at their lead byte.
    assign w_cp_start = w_evt.lead ? r_pos : r_seq_start;

    // Input register: loads whenever the stage is open.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
        if (w_in_accept) begin
            r_s1_byte    <= i_data_byte;
            r_s1_present <= i_byte_present;
            r_s1_end     <= i_end_of_text;
        end
    end

    // One pass over the registered beat: decode, track the trimmed span, and at
    // end of text form the verdict and clear for the next text.
    always_comb begin
        n_dec       = r_dec;
        n_pos       = r_pos;
        n_seq_start = r_seq_start;
        n_cp_idx    = r_cp_idx;
        n_found     = r_found;
        n_first_off = r_first_off;
        n_first_idx = r_first_idx;
        n_last_end  = r_last_end;
        n_last_idx  = r_last_idx;
        n_err       = r_err;
        n_status    = ST_OK;
        n_tb        = '0;
        n_te        = '0;
        n_cnt       = '0;
        w_span_cnt  = '0;
        w_first32   = '0;
        w_last32    = '0;
        w_cnt32     = '0;

        if (r_s1_present && r_err == ST_OK) begin
            if (r_pos == POS_LIMIT) begin
                n_err = ST_TOO_LONG;
            end else begin
                n_dec = w_dec_next;
                n_pos = w_pos_inc;
                if (w_evt.lead) begin
                    n_seq_start = r_pos;
                end
                if (w_evt.bad) begin
                    n_err = ST_INVALID;
                end
                if (w_evt.done) begin
                    if (!w_evt.space) begin
                        if (!r_found) begin
                            n_found     = 1'b1;
                            n_first_off = w_cp_start;
                            n_first_idx = r_cp_idx;
                        end
                        n_last_end = w_pos_inc;
                        n_last_idx = r_cp_idx;
                    end
                    n_cp_idx = r_cp_idx + 1'b1;
                end
            end
        end

        if (r_s1_end) begin
            // A sequence cut off by the end of the text is invalid.
            if (n_err == ST_OK && n_dec.pending != 2'd0) begin
                n_err = ST_INVALID;
            end
            w_span_cnt = n_last_idx - n_first_idx + 1'b1;
            w_first32  = 32'(n_first_off);
            w_last32   = 32'(n_last_end);
            w_cnt32    = 32'(w_span_cnt);
            if (n_err != ST_OK) begin
                n_status = n_err;
            end else if (!n_found) begin
                n_status = ST_EMPTY;
            end else begin
                n_tb     = w_first32[TB_W-1:0];
                n_te     = w_last32[TE_W-1:0];
                n_cnt    = w_cnt32[CNT_W-1:0];
                n_status = (w_cnt32 > 32'(r_max_cp)) ? ST_TOO_MANY : ST_OK;
            end
            n_dec       = '0;
            n_pos       = '0;
            n_seq_start = '0;
            n_cp_idx    = '0;
            n_found     = 1'b0;
            n_first_off = '0;
            n_first_idx = '0;
            n_last_end  = '0;
            n_last_idx  = '0;
            n_err       = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec       <= '0;
            r_pos       <= '0;
            r_seq_start <= '0;
            r_cp_idx    <= '0;
            r_found     <= 1'b0;
            r_first_off <= '0;
            r_first_idx <= '0;
            r_last_end  <= '0;
            r_last_idx  <= '0;
            r_err       <= ST_OK;
        end else if (w_s1_adv) begin
            r_dec       <= n_dec;
            r_pos       <= n_pos;
            r_seq_start <= n_seq_start;
            r_cp_idx    <= n_cp_idx;
            r_found     <= n_found;
            r_first_off <= n_first_off;
            r_first_idx <= n_first_idx;
            r_last_end  <= n_last_end;
            r_last_idx  <= n_last_idx;
            r_err       <= n_err;
        end
    end

    // Limit register; to be written only between texts, which the user must ensure, unenforced by the block.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_cp <= MAXCP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_cp <= i_cfg_data;
        end
    end

    // Result register: loads a verdict, empties when the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv && r_s1_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_s1_adv && r_s1_end) begin
            r_status <= n_status;
            r_tb     <= n_tb;
            r_te     <= n_te;
            r_cnt    <= n_cnt;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_trim_begin = r_tb;
    assign o_trim_end   = r_te;
    assign o_cp_count   = r_cnt;

    // After an end-of-text beat is processed, the text state starts over.
    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && r_s1_end) |=> (r_pos == '0 && r_err == ST_OK && !r_found &&
                                    r_dec.pending == 2'd0))
        else $error("text state not cleared after end of text");

    // The byte position never passes the text limit.
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LIMIT)
        else $error("byte position beyond limit");

    // The last non-whitespace codepoint never precedes the first one.
    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_last_idx >= r_first_idx && r_last_end > r_first_off))
        else $error("trimmed span out of order");

    // Verdicts without a span carry zero fields.
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_INVALID || r_status == ST_EMPTY ||
                         r_status == ST_TOO_LONG))
        |-> (r_tb == '0 && r_te == '0 && r_cnt == '0))
        else $error("nonzero span on an error verdict");

endmodule

[sv/utf8vtc_decode.sv]
// Single-byte strict UTF-8 decoder step: next decoder state and byte events.
module utf8vtc_decode
    import utf8vtc_pkg::*;
(
    input  logic [7:0] i_byte,
    input  t_dec_state i_cur,
    output t_dec_state o_next,
    output t_dec_evt   o_evt
);

    logic [CP_W-1:0] w_cont;
    logic [CP_W-1:0] w_cp;

    assign w_cont = {i_cur.partial[CP_W-7:0], i_byte[5:0]};

    always_comb begin
        o_next = i_cur;
        o_evt  = '0;
        w_cp   = '0;
        if (i_cur.pending == 2'd0) begin
            if (!i_byte[7]) begin
                o_evt.lead     = 1'b1;
                o_evt.done     = 1'b1;
                o_next.seq_len = SEQ_LEN1;
                o_next.partial = {{(CP_W-8){1'b0}}, i_byte};
                w_cp           = {{(CP_W-8){1'b0}}, i_byte};
            end else if (i_byte >= LEAD2_MIN && i_byte <= LEAD2_MAX) begin
                o_evt.lead     = 1'b1;
                o_next.seq_len = SEQ_LEN2;
                o_next.partial = {{(CP_W-5){1'b0}}, i_byte[4:0]};
                o_next.pending = 2'd1;
            end else if (i_byte >= LEAD3_MIN && i_byte <= LEAD3_MAX) begin
                o_evt.lead     = 1'b1;
                o_next.seq_len = SEQ_LEN3;
                o_next.partial = {{(CP_W-4){1'b0}}, i_byte[3:0]};
                o_next.pending = 2'd2;
            end else if (i_byte >= LEAD4_MIN && i_byte <= LEAD4_MAX) begin
                o_evt.lead     = 1'b1;
                o_next.seq_len = SEQ_LEN4;
                o_next.partial = {{(CP_W-3){1'b0}}, i_byte[2:0]};
                o_next.pending = 2'd3;
            end else begin
                o_evt.bad = 1'b1;
            end
        end else if (i_byte[7:6] != 2'b10) begin
            o_evt.bad = 1'b1;
        end else begin
            o_next.partial = w_cont;
            o_next.pending = i_cur.pending - 2'd1;
            if (i_cur.pending == 2'd1) begin
                if ((i_cur.seq_len == SEQ_LEN3 && w_cont < CP_MIN3) ||
                    (i_cur.seq_len == SEQ_LEN4 && w_cont < CP_MIN4) ||
                    (w_cont >= CP_SURR_LO && w_cont <= CP_SURR_HI) ||
                    (w_cont > CP_MAX)) begin
                    o_evt.bad = 1'b1;
                end else begin
                    o_evt.done = 1'b1;
                    w_cp       = w_cont;
                end
            end
        end
        if (o_evt.done) begin
            o_next.seq_len = 3'd0;
            o_evt.space    = is_space(w_cp);
        end
    end

endmodule
